### rtl/core/fs4hb_pkg.sv
// ----------------------------------------------------------------------------
// fs4hb_pkg: shared types and constants
// Word widths, register indexes and arithmetic helpers for the converter.
// ----------------------------------------------------------------------------
package fs4hb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_OFFSET = 3'd0,
    REG_DC_ALPHA      = 3'd1,
    REG_CENTER_TAP    = 3'd2,
    REG_COEF_ADDR     = 3'd3,
    REG_COEF_DATA     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic       valid;
    logic [1:0] phase;
  } fir_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic signed [15:0] round17(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v + 48'sd65536) >>> 17;
    return sat16(t);
  endfunction

endpackage

### rtl/core/fs4hb_stream_if.sv
// ----------------------------------------------------------------------------
// fs4hb_stream_if: valid/ready channel
// Carries one word with its payload between a source and a sink.
// ----------------------------------------------------------------------------
interface fs4hb_stream_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fs4_halfband_iq_converter_top.sv
// ----------------------------------------------------------------------------
// fs4_halfband_iq_converter_top: real ADC stream to I/Q at fs/4
// Path: a Q word passes the stage-1 register and the output register; an I word
// waits for the partial sum to cross the cell row before it reaches the output register.
// Flow: one word in flight; the next input is taken as the result leaves, and is
// held off while the output stalls.
// Reset clears history, delay line, DC average and phase; coefficients unset.
// ----------------------------------------------------------------------------
module fs4_halfband_iq_converter_top
  import fs4hb_pkg::*;
#(
  parameter int unsigned FIR_TAPS    = 42,
  parameter int unsigned DELAY_DEPTH = 21,
  parameter int unsigned SAMPLE_BITS = 12
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fs4hb_stream_if.sink        in_if,
  fs4hb_stream_if.source      out_if
);
  localparam int unsigned Pairs = FIR_TAPS / 2;
  localparam int unsigned DpW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned CaW = 5;
  localparam int unsigned CntW = $clog2(Pairs + 2);

  logic [11:0]        offset_q;
  logic [15:0]        alpha_q;
  logic signed [17:0] center_q;
  logic [CaW-1:0]     caddr_q;
  logic signed [17:0] coef_q [Pairs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 12'd2048;
      alpha_q  <= 16'd655;
      center_q <= 18'sd65536;
      caddr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_OFFSET: offset_q <= cfg_data_i[11:0];
        REG_DC_ALPHA:      alpha_q  <= cfg_data_i[15:0];
        REG_CENTER_TAP:    center_q <= $signed(cfg_data_i);
        REG_COEF_ADDR:     caddr_q  <= cfg_data_i[CaW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Pairs; k++) begin
      if (cfg_we_i && cfg_idx_i == REG_COEF_DATA && 32'(caddr_q) == k) begin
        coef_q[k] <= $signed(cfg_data_i);
      end
    end
  end

  // stage 1: scale, DC removal, mix
  logic               busy_q;
  logic signed [31:0] dc_q;
  logic [1:0]         phase_q;
  logic signed [15:0] v_q;
  logic [1:0]         vph_q;
  logic               out_valid_q;
  logic signed [15:0] out_val_q;
  logic               out_isq_q;
  logic [CntW-1:0]    fir_cnt_q;
  logic               fir_done;

  logic [SAMPLE_BITS-1:0] raw;
  logic signed [47:0]     diff;
  logic signed [15:0]     s_val;
  logic signed [15:0]     x_val;
  logic signed [15:0]     v_val;
  logic signed [47:0]     dc_sum;
  logic                   accept;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = !busy_q && (fir_cnt_q == '0) && !(out_valid_q && !out_if.ready);
  assign raw = in_if.data[SAMPLE_BITS-1:0];
  assign diff = (48'($unsigned(raw)) - 48'($unsigned(offset_q))) <<< (16 - SAMPLE_BITS);
  assign s_val = sat16(diff);
  assign x_val = sat16(48'(s_val) - 48'(dc_q >>> 16));
  assign v_val = (phase_q < 2'd2) ? sat16(-48'(x_val)) : x_val;
  assign dc_sum = 48'(dc_q) + 48'($signed({1'b0, alpha_q})) * 48'(x_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= '0;
      phase_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      if (accept) begin
        if (dc_sum > 48'sh7fffffff) begin
          dc_q <= 32'sh7fffffff;
        end else if (dc_sum < -48'sh80000000) begin
          dc_q <= 32'sh80000000;
        end else begin
          dc_q <= dc_sum[31:0];
        end
        phase_q <= phase_q + 2'd1;
        busy_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q   <= v_val;
      vph_q <= phase_q;
    end
  end

  // stage 2: cell row (FIR) and delay line
  logic               shift;
  logic signed [15:0] fwd  [Pairs+1];
  logic signed [15:0] bwd  [Pairs+1];
  logic signed [47:0] acc  [Pairs+1];
  logic signed [15:0] tail_q;

  assign shift  = busy_q && !vph_q[0];
  assign fwd[0] = v_q;
  assign acc[0] = '0;
  // backward chain is fed by the oldest entry of the forward chain
  assign bwd[Pairs] = (FIR_TAPS % 2 == 1) ? tail_q : fwd[Pairs];
  assign fir_done = (fir_cnt_q == CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
    end else if (shift) begin
      tail_q <= fwd[Pairs];
    end
  end

  // hold the taps until the partial sum has crossed the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fir_cnt_q <= '0;
    end else if (shift) begin
      fir_cnt_q <= CntW'(Pairs + 1);
    end else if (fir_cnt_q != '0) begin
      fir_cnt_q <= fir_cnt_q - CntW'(1);
    end
  end

  for (genvar k = 0; k < Pairs; k++) begin : g_cell
    fs4hb_tap_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .fwd_i  (fwd[k]),
      .bwd_i  (bwd[k+1]),
      .coef_i (coef_q[k]),
      .acc_i  (acc[k]),
      .fwd_o  (fwd[k+1]),
      .bwd_o  (bwd[k]),
      .acc_o  (acc[k+1])
    );
  end

  logic signed [15:0] dl_q [DELAY_DEPTH];
  logic [DpW-1:0]     dp_q;
  logic signed [47:0] qprod;

  assign qprod = 48'(v_q) * 48'(center_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) dl_q[i] <= '0;
    end else if (busy_q && vph_q[0]) begin
      dl_q[dp_q] <= round17(qprod);
      dp_q <= (32'(dp_q) == DELAY_DEPTH - 1) ? '0 : dp_q + DpW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((busy_q && vph_q[0]) || fir_done) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && vph_q[0]) begin
      out_isq_q <= 1'b1;
      out_val_q <= dl_q[dp_q];
    end else if (fir_done) begin
      out_isq_q <= 1'b0;
      out_val_q <= round17(acc[Pairs]);
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = {out_isq_q, out_val_q};

  initial_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q) else $error("stage 1 lost");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept) else $error("overlap");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && vph_q[0]) |=> out_valid_q) else $error("result lost");
  a_fir_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fir_done |=> out_valid_q) else $error("fir result lost");
  a_fir_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fir_cnt_q != '0) |-> !in_if.ready) else $error("input taken during fir sum");
endmodule

### rtl/core/fs4hb_tap_cell.sv
// ----------------------------------------------------------------------------
// fs4hb_tap_cell: one systolic FIR pair cell
// Holds forward and backward sample taps, multiplies their sum by its
// coefficient and adds the product to the partial sum from its neighbor.
// ----------------------------------------------------------------------------
module fs4hb_tap_cell
  import fs4hb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic signed [15:0]  fwd_i,
  input  logic signed [15:0]  bwd_i,
  input  logic signed [17:0]  coef_i,
  input  logic signed [47:0]  acc_i,
  output logic signed [15:0]  fwd_o,
  output logic signed [15:0]  bwd_o,
  output logic signed [47:0]  acc_o
);
  logic signed [15:0] fwd_q;
  logic signed [15:0] bwd_q;
  logic signed [47:0] acc_q;
  logic signed [35:0] prod;

  assign prod  = coef_i * ($signed({fwd_q[15], fwd_q}) + $signed({bwd_q[15], bwd_q}));
  assign acc_o = acc_q;
  assign fwd_o = fwd_q;
  assign bwd_o = bwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      bwd_q <= '0;
      acc_q <= '0;
    end else begin
      acc_q <= acc_i + 48'(prod);
      if (shift_i) begin
        fwd_q <= fwd_i;
        bwd_q <= bwd_i;
      end
    end
  end
endmodule
